// ===== design/sqz_pkg.sv =====
// shared types and constants of the squeeze stream decoder
package sqz_pkg;

  localparam int TREE_NODES = 256;
  localparam int NODE_W     = 8;
  localparam int CHILD_W    = 10;
  localparam int ENTRY_W    = 2 * CHILD_W;
  localparam int SYM_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int BIT_CNT_W  = 3;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  localparam logic [BYTE_W-1:0]  ESCAPE_SYM = 8'h90;
  localparam logic [BYTE_W-1:0]  EOF_BYTE   = 8'h1A;
  localparam logic [SYM_W-1:0]   END_SYM    = 9'd256;
  // empty tree: both children are leaves of the end symbol
  localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = {10'h2FF, 10'h2FF};

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_DATA  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [NODE_W-1:0]         node_index;
    logic signed [CHILD_W-1:0] left_child;
    logic signed [CHILD_W-1:0] right_child;
    logic [BYTE_W-1:0]         coded_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] repeat_res;
    logic              end_of_stream;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ended;
    logic walk_done;
    logic flush_done;
  } dp_status_t;

endpackage

// ===== design/sqz_if.sv =====
// stream interfaces of the squeeze stream decoder
interface sqz_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic [sqz_pkg::NODE_W-1:0]          node_index;
  logic signed [sqz_pkg::CHILD_W-1:0]  left_child;
  logic signed [sqz_pkg::CHILD_W-1:0]  right_child;
  logic [sqz_pkg::BYTE_W-1:0]          coded_byte;

  modport source (output valid, opcode, node_index, left_child, right_child, coded_byte,
                  input ready);
  modport sink (input valid, opcode, node_index, left_child, right_child, coded_byte,
                output ready);
endinterface

interface sqz_out_if;
  logic                       valid;
  logic                       ready;
  logic [sqz_pkg::BYTE_W-1:0] out_byte;
  logic [sqz_pkg::BYTE_W-1:0] repeat_res;
  logic                       end_of_stream;
  logic                       last;

  modport source (output valid, out_byte, repeat_res, end_of_stream, last, input ready);
  modport sink (input valid, out_byte, repeat_res, end_of_stream, last, output ready);
endinterface

// ===== design/sqz_ram.sv =====
// generic single-port-write ram with registered read (read-first)
module sqz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sqz_ctrl.sv =====
// sequencing state machine of the squeeze stream decoder
module sqz_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_opcode_i,
  output logic                in_ready_o,
  input  sqz_pkg::dp_status_t status_i,
  output sqz_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   accept;

  assign accept = in_valid_i && in_ready_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_opcode_i == sqz_pkg::OP_DATA && !status_i.ended) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_WALK;
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.flush_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o   = in_ready_q;
  assign cmd_o.accept = accept;
  assign cmd_o.walk   = (state_q == ST_WALK);
  assign cmd_o.flush  = (state_q == ST_FLUSH);

endmodule

// ===== design/sqz_datapath.sv =====
// tree walk, run-length stage and result registers
module sqz_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqz_pkg::in_item_t   in_item_i,
  input  sqz_pkg::ctrl_cmd_t  cmd_i,
  output sqz_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sqz_pkg::out_item_t  out_item_o
);

  // control state
  logic [sqz_pkg::NODE_W-1:0]    walk_q, walk_d;
  logic [sqz_pkg::BYTE_W-1:0]    prev_q, prev_d;
  logic                          expect_q, expect_d;
  logic                          ended_q, ended_d;
  logic                          node0_empty_q, node0_empty_d;
  logic                          rd_empty_q, rd_empty_d;
  logic [sqz_pkg::BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  logic                          out_valid_q, out_valid_d;
  // payload
  logic [sqz_pkg::BYTE_W-1:0]    byte_q, byte_d;
  sqz_pkg::out_item_t            pend_q, pend_d;
  sqz_pkg::out_item_t            out_q, out_d;

  logic [sqz_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [sqz_pkg::ENTRY_W-1:0]   entry;
  logic [sqz_pkg::CHILD_W-1:0]   raw;
  logic [sqz_pkg::SYM_W-1:0]     sym_raw;
  logic [sqz_pkg::SYM_W-1:0]     sym;
  logic                          is_leaf;
  logic                          hit;
  logic                          fin;
  logic                          expect_n;
  logic [sqz_pkg::BYTE_W-1:0]    prev_n;
  sqz_pkg::out_item_t            res;
  logic                          slot_free;
  logic                          stall;
  logic                          step;
  logic                          load_we;

  assign load_we   = cmd_i.accept && in_item_i.opcode == sqz_pkg::OP_LOAD;
  assign slot_free = !out_valid_q || out_ready_i;

  // child select and symbol decode for the current bit
  always_comb begin
    entry    = rd_empty_q ? sqz_pkg::EMPTY_ENTRY : ram_rdata;
    raw      = byte_q[0] ? entry[sqz_pkg::ENTRY_W-1:sqz_pkg::CHILD_W]
                         : entry[sqz_pkg::CHILD_W-1:0];
    is_leaf  = raw[sqz_pkg::CHILD_W-1];
    sym_raw  = ~raw[sqz_pkg::SYM_W-1:0];
    sym      = (sym_raw > sqz_pkg::END_SYM) ? sqz_pkg::END_SYM : sym_raw;
    hit      = 1'b0;
    fin      = 1'b0;
    expect_n = expect_q;
    prev_n   = prev_q;
    res      = '{out_byte: sym[sqz_pkg::BYTE_W-1:0], repeat_res: 8'd1,
                 end_of_stream: 1'b0, last: 1'b0};
    if (expect_q) begin
      expect_n = 1'b0;
      if (sym == sqz_pkg::END_SYM) begin
        fin = 1'b1;
      end else if (sym == '0) begin
        hit          = 1'b1;
        res.out_byte = sqz_pkg::ESCAPE_SYM;
      end else begin
        hit          = 1'b1;
        res.out_byte = prev_q;
        if (sym > 9'd1) begin
          res.repeat_res = sym[sqz_pkg::BYTE_W-1:0] - 8'd1;
        end
      end
    end else if (sym == {1'b0, sqz_pkg::ESCAPE_SYM}) begin
      expect_n = 1'b1;
    end else if (sym == sqz_pkg::END_SYM || sym == {1'b0, sqz_pkg::EOF_BYTE}) begin
      fin = 1'b1;
    end else begin
      hit    = 1'b1;
      prev_n = sym[sqz_pkg::BYTE_W-1:0];
    end
    if (fin) begin
      hit = 1'b1;
      res = '{out_byte: sqz_pkg::EOF_BYTE, repeat_res: 8'd0,
              end_of_stream: 1'b1, last: 1'b0};
    end
  end

  // a second result needs the output slot for the held one
  assign stall = cmd_i.walk && is_leaf && hit && pend_valid_q && !slot_free;
  assign step  = cmd_i.walk && !stall;

  always_comb begin
    walk_d        = walk_q;
    prev_d        = prev_q;
    expect_d      = expect_q;
    ended_d       = ended_q;
    node0_empty_d = node0_empty_q;
    cnt_d         = cnt_q;
    byte_d        = byte_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;

    if (cmd_i.accept) begin
      case (in_item_i.opcode)
        sqz_pkg::OP_START: begin
          walk_d        = '0;
          prev_d        = '0;
          expect_d      = 1'b0;
          ended_d       = 1'b0;
          node0_empty_d = 1'b1;
        end
        sqz_pkg::OP_LOAD: begin
          if (in_item_i.node_index == '0) begin
            node0_empty_d = 1'b0;
          end
        end
        sqz_pkg::OP_DATA: begin
          byte_d = in_item_i.coded_byte;
          cnt_d  = '0;
        end
        default: ;
      endcase
    end

    if (step) begin
      byte_d = byte_q >> 1;
      cnt_d  = cnt_q + 3'd1;
      if (is_leaf) begin
        walk_d   = '0;
        prev_d   = prev_n;
        expect_d = expect_n;
        if (fin) begin
          ended_d = 1'b1;
        end
        if (hit) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d = 1'b1;
          pend_d       = res;
        end
      end else begin
        walk_d = raw[sqz_pkg::NODE_W-1:0];
      end
    end

    if (cmd_i.flush && pend_valid_q && slot_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // read data always belongs to the node in walk_q
  assign rd_empty_d = node0_empty_d && walk_d == '0;

  sqz_ram #(
    .WIDTH(sqz_pkg::ENTRY_W),
    .DEPTH(sqz_pkg::TREE_NODES)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(in_item_i.node_index),
    .wdata_i({in_item_i.right_child, in_item_i.left_child}),
    .raddr_i(walk_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q        <= '0;
      prev_q        <= '0;
      expect_q      <= 1'b0;
      ended_q       <= 1'b0;
      node0_empty_q <= 1'b1;
      rd_empty_q    <= 1'b1;
      cnt_q         <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      walk_q        <= walk_d;
      prev_q        <= prev_d;
      expect_q      <= expect_d;
      ended_q       <= ended_d;
      node0_empty_q <= node0_empty_d;
      rd_empty_q    <= rd_empty_d;
      cnt_q         <= cnt_d;
      pend_valid_q  <= pend_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign status_o.ended      = ended_q;
  assign status_o.walk_done  = step && (cnt_q == sqz_pkg::LAST_BIT || (is_leaf && fin));
  assign status_o.flush_done = !pend_valid_q || slot_free;
  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;

endmodule

// ===== design/squeeze_huffman_rle_decoder.sv =====
// top level of the squeeze huffman and run-length stream decoder
//
// in_i carries one command per transfer: start stream, load one tree node
// (both children into a 256-entry tree ram), or one coded byte. out_o carries
// decoded results: a byte, its repeat count, an end-of-stream flag and a last
// flag on the final result of that coded byte.
// start and load transfers give no result. A coded byte first fetches the
// current node from the tree ram, then walks one bit per cycle unless a
// stall on out_o holds it (eight bits, fewer when the stream ends inside the
// byte), then hands over its final result; in_i takes the next coded byte
// only after that. The pace is set by the chain of dependent tree ram
// reads, one per bit. A result leaves for out_o when the next result of the
// same byte is found; the final result goes to out_o in the flush state
// after the walk.
// Reset leaves an empty tree (node 0 decodes to end of stream) and clears the
// run-length state; other tree nodes hold nothing useful until loaded.
// When out_o stalls, the walk holds on the bit that produced a second result
// until the output register frees; in_i takes no new item until then.
module squeeze_huffman_rle_decoder (
  input logic     clk_i,
  input logic     rst_ni,
  sqz_in_if.sink  in_i,
  sqz_out_if.source out_o
);

  sqz_pkg::in_item_t   in_item;
  sqz_pkg::out_item_t  out_item;
  sqz_pkg::ctrl_cmd_t  cmd;
  sqz_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;

  assign in_item.opcode      = in_i.opcode;
  assign in_item.node_index  = in_i.node_index;
  assign in_item.left_child  = in_i.left_child;
  assign in_item.right_child = in_i.right_child;
  assign in_item.coded_byte  = in_i.coded_byte;

  sqz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_opcode_i(in_i.opcode),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sqz_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .out_item_o (out_item)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.out_byte      = out_item.out_byte;
  assign out_o.repeat_res    = out_item.repeat_res;
  assign out_o.end_of_stream = out_item.end_of_stream;
  assign out_o.last          = out_item.last;

endmodule

// ===== design/sqz_checker.sv =====
// port-level checks of the squeeze stream decoder and their binding
module sqz_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [1:0]                 in_opcode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sqz_pkg::BYTE_W-1:0] out_byte_i,
  input logic [sqz_pkg::BYTE_W-1:0] out_repeat_i,
  input logic                       out_eos_i,
  input logic                       out_last_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // end of stream is always the final eof result with no repeat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eos_i |->
      out_last_i && out_repeat_i == 8'd0 && out_byte_i == sqz_pkg::EOF_BYTE)
    else $error("malformed end-of-stream result");

  // ordinary results emit at least once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_eos_i |-> out_repeat_i != 8'd0)
    else $error("zero repeat on a data result");

  // start, load and unused-opcode transfers finish at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_opcode_i != sqz_pkg::OP_DATA |=> in_ready_i)
    else $error("input blocked after a start or load transfer");

endmodule

bind squeeze_huffman_rle_decoder sqz_checker u_sqz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_repeat_i(out_o.repeat_res),
  .out_eos_i   (out_o.end_of_stream),
  .out_last_i  (out_o.last)
);

// ===== tb/sv/squeeze_huffman_rle_decoder_tb.sv =====
// testbench of the squeeze huffman and run-length stream decoder with a built-in predictor
`timescale 1ns / 1ps

module squeeze_huffman_rle_decoder_tb;
  import sqz_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;

  sqz_in_if  in_bus ();
  sqz_out_if out_bus ();

  squeeze_huffman_rle_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // command stream waiting for the driver, and runs predicted but not yet seen
  in_item_t  cmd_q[$];
  out_item_t predicted_runs[$];
  out_item_t byte_runs[$];

  // predictor state
  logic [ENTRY_W-1:0] tree_mem [TREE_NODES];
  logic [NODE_W-1:0]  cur_node;
  logic [BYTE_W-1:0]  last_byte;
  logic               escape_seen;
  logic               stream_done;

  // nodes whose children are known to be safe to walk
  bit node_loaded [TREE_NODES];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic out_hold       = 1'b0;
  logic in_taken       = 1'b0;
  event hold_go;

  int cycle_cnt    = 0;
  int accepted_cnt = 0;
  int coded_cnt    = 0;
  int checked_cnt  = 0;
  int end_cnt      = 0;
  int mismatch_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------- predictor

  function automatic out_item_t make_run(logic [7:0] value, logic [7:0] times, logic eos);
    out_item_t r;
    r.out_byte      = value;
    r.repeat_res    = times;
    r.end_of_stream = eos;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic void open_stream();
    tree_mem[0] = EMPTY_ENTRY;
    cur_node    = '0;
    last_byte   = '0;
    escape_seen = 1'b0;
    stream_done = 1'b0;
  endfunction

  function automatic void close_stream();
    byte_runs.push_back(make_run(EOF_BYTE, 8'd0, 1'b1));
    stream_done = 1'b1;
  endfunction

  function automatic void rle_symbol(logic [SYM_W-1:0] sym);
    if (escape_seen) begin
      escape_seen = 1'b0;
      if (sym == END_SYM) close_stream();
      else if (sym == '0) byte_runs.push_back(make_run(ESCAPE_SYM, 8'd1, 1'b0));
      else byte_runs.push_back(make_run(last_byte, (sym > 9'd1) ? 8'(sym - 9'd1) : 8'd1,
                                        1'b0));
    end else if (sym == {1'b0, ESCAPE_SYM}) begin
      escape_seen = 1'b1;
    end else if (sym == END_SYM || sym == {1'b0, EOF_BYTE}) begin
      close_stream();
    end else begin
      last_byte = sym[7:0];
      byte_runs.push_back(make_run(sym[7:0], 8'd1, 1'b0));
    end
  endfunction

  function automatic void walk_coded_byte(logic [7:0] cb);
    logic [ENTRY_W-1:0] entry;
    logic [CHILD_W-1:0] raw;
    logic [CHILD_W-1:0] val;
    int b;
    byte_runs.delete();
    for (b = 0; b < 8 && !stream_done; b++) begin
      entry = tree_mem[cur_node];
      raw   = cb[b] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];
      if (!raw[CHILD_W-1]) begin
        cur_node = raw[NODE_W-1:0];
      end else begin
        val      = 10'h3FF - raw;
        cur_node = '0;
        // leaves past the end symbol count as the end symbol
        rle_symbol((val > 10'd256) ? END_SYM : val[SYM_W-1:0]);
      end
    end
    if (byte_runs.size() != 0) byte_runs[byte_runs.size() - 1].last = 1'b1;
    foreach (byte_runs[i]) predicted_runs.push_back(byte_runs[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CHILD_W-1:0] leaf_code(int sym);
    return 10'h3FF - 10'(sym);
  endfunction

  function automatic logic [CHILD_W-1:0] pick_leaf();
    int r;
    int sym;
    r = $urandom_range(99);
    if (r < 14) sym = int'(ESCAPE_SYM);
    else if (r < 20) sym = int'(END_SYM);
    else if (r < 25) sym = int'(EOF_BYTE);
    else if (r < 32) sym = 0;
    else if (r < 42) sym = $urandom_range(1, 3);
    else if (r < 45) sym = 255;
    else if (r < 47) sym = $urandom_range(257, 511);
    else sym = $urandom_range(0, 255);
    return leaf_code(sym);
  endfunction

  function automatic void queue_cmd(int op, int idx, int lc, int rc, int cb);
    in_item_t it;
    it.opcode      = 2'(op);
    it.node_index  = 8'(idx);
    it.left_child  = 10'(lc);
    it.right_child = 10'(rc);
    it.coded_byte  = 8'(cb);
    if (it.opcode == OP_LOAD) node_loaded[it.node_index] = 1'b1;
    cmd_q.push_back(it);
  endfunction

  function automatic logic [CHILD_W-1:0] any_loaded_node();
    int id;
    do id = $urandom_range(0, 255); while (!node_loaded[id]);
    return 10'(id);
  endfunction

  // grows a random tree from root 0, then loads it leaves-up so no walk meets an unloaded node
  function automatic int queue_tree(int inner);
    int                 ids[$];
    int                 open_slots[$];
    logic [CHILD_W-1:0] kids[$];
    bit                 taken[256];
    int                 pick, slot, id, k;
    ids.push_back(0);
    taken[0] = 1'b1;
    kids.push_back(pick_leaf());
    kids.push_back(pick_leaf());
    open_slots.push_back(0);
    open_slots.push_back(1);
    for (k = 1; k < inner; k++) begin
      pick = $urandom_range(0, open_slots.size() - 1);
      slot = open_slots[pick];
      open_slots.delete(pick);
      do id = $urandom_range(1, 255); while (taken[id]);
      taken[id] = 1'b1;
      // now and then the index carries bit 8, which the block drops
      kids[slot] = ($urandom_range(99) < 4) ? 10'(id + 256) : 10'(id);
      open_slots.push_back(2 * ids.size());
      open_slots.push_back(2 * ids.size() + 1);
      ids.push_back(id);
      kids.push_back(pick_leaf());
      kids.push_back(pick_leaf());
    end
    for (k = ids.size() - 1; k >= 0; k--)
      queue_cmd(OP_LOAD, ids[k], kids[2 * k], kids[2 * k + 1], $urandom);
    return ids.size();
  endfunction

  function automatic void queue_streams(int goal);
    int made;
    int pick;
    int n;
    made = 0;
    while (made < goal) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 12) begin
        queue_cmd(OP_LOAD, $urandom,
                  $urandom_range(1) ? pick_leaf() : any_loaded_node(),
                  $urandom_range(1) ? pick_leaf() : any_loaded_node(), $urandom);
        made++;
      end else begin
        if ($urandom_range(9) != 0) queue_cmd(OP_START, $urandom, $urandom, $urandom, $urandom);
        // without a tree after a start the stream decodes against the empty tree
        if ($urandom_range(9) != 0)
          made += queue_tree(($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8));
        n = $urandom_range(1, 10);
        repeat (n) queue_cmd(OP_DATA, $urandom, $urandom, $urandom, $urandom);
        made += n;
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver and receiver

  always @(negedge clk_i) begin : drive_in
    in_item_t nxt;
    if (rst_ni && (!in_bus.valid || in_taken)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_q.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= nxt.opcode;
        in_bus.node_index  <= nxt.node_index;
        in_bus.left_child  <= nxt.left_child;
        in_bus.right_child <= nxt.right_child;
        in_bus.coded_byte  <= nxt.coded_byte;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || out_hold) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the output backs up into the input
  initial begin : hold_ctl
    forever begin
      @(hold_go);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      out_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch
    out_item_t want;
    in_taken <= in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      accepted_cnt++;
      case (in_bus.opcode)
        OP_START: open_stream();
        OP_LOAD:  tree_mem[in_bus.node_index] = {in_bus.right_child, in_bus.left_child};
        OP_DATA: begin
          coded_cnt++;
          walk_coded_byte(in_bus.coded_byte);
        end
        default: ;
      endcase
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      checked_cnt++;
      if (out_bus.end_of_stream) end_cnt++;
      if (predicted_runs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: byte %02h rep %0d eos %0b last %0b", out_bus.out_byte,
                   out_bus.repeat_res, out_bus.end_of_stream, out_bus.last);
      end else begin
        want = predicted_runs.pop_front();
        if (out_bus.out_byte !== want.out_byte || out_bus.repeat_res !== want.repeat_res ||
            out_bus.end_of_stream !== want.end_of_stream || out_bus.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"result %0d: expected byte %02h rep %0d eos %0b last %0b, ",
                      "got %02h %0d %0b %0b"},
                     checked_cnt, want.out_byte, want.repeat_res, want.end_of_stream, want.last,
                     out_bus.out_byte, out_bus.repeat_res, out_bus.end_of_stream, out_bus.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  task automatic drain();
    while (cmd_q.size() != 0 || in_bus.valid || predicted_runs.size() != 0) @(negedge clk_i);
  endtask

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("squeeze_huffman_rle_decoder_tb NOT OK");
    $finish;
  end

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.opcode      = OP_START;
    in_bus.node_index  = '0;
    in_bus.left_child  = '0;
    in_bus.right_child = '0;
    in_bus.coded_byte  = '0;
    out_bus.ready      = 1'b0;
    node_loaded[0]     = 1'b1;
    open_stream();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty tree after reset, then a byte past the end
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'hFF);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h00);
    queue_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(OP_START, $urandom, $urandom, $urandom, $urandom);
    // two-bit codes; the right half of the root is reached through an aliased index
    queue_cmd(OP_LOAD, 8'd1, leaf_code(8'h41), leaf_code(ESCAPE_SYM), $urandom);
    queue_cmd(OP_LOAD, 8'd2, leaf_code(0), leaf_code(3), $urandom);
    queue_cmd(OP_LOAD, 8'd0, 10'd1, 10'd258, $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'hB8);  // escape left open at byte end
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h61);  // escape then zero, twice
    queue_cmd(OP_LOAD, 8'd2, leaf_code(1), leaf_code(255), $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'hE6);  // repeat counts 1 and 254
    queue_cmd(OP_LOAD, 8'd1, leaf_code(EOF_BYTE), leaf_code(8'hFF), $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'hF2);  // literal end byte mid-byte
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h55);
    queue_cmd(OP_START, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(OP_LOAD, 8'd1, leaf_code(0), leaf_code(300), $urandom);
    queue_cmd(OP_LOAD, 8'd2, leaf_code(ESCAPE_SYM), leaf_code(END_SYM), $urandom);
    queue_cmd(OP_LOAD, 8'd0, 10'd1, 10'd258, $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h34);  // zero byte, escape then end
    queue_cmd(OP_START, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(OP_LOAD, 8'd0, 10'd1, 10'd258, $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h02);  // leaf above the end symbol
    queue_cmd(OP_START, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(OP_DATA, $urandom, $urandom, $urandom, 8'h00);
    queue_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    queue_streams(20);
    drain();

    send_idle_pct = 45;
    queue_streams(20);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 45;
    queue_streams(20);
    drain();

    send_idle_pct  = 19;
    recv_stall_pct = 19;
    queue_streams(20);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    queue_streams(20);
    drain();

    repeat (40) @(negedge clk_i);
    $display("covered %0d transfers in (%0d coded bytes), %0d results out, %0d stream ends",
             accepted_cnt, coded_cnt, checked_cnt, end_cnt);
    $display("mismatches %0d, results still outstanding %0d", mismatch_cnt,
             predicted_runs.size());
    if (mismatch_cnt == 0 && predicted_runs.size() == 0) begin
      $display("squeeze_huffman_rle_decoder_tb OK");
    end else begin
      $display("squeeze_huffman_rle_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
